FILE: hdl/sharded_token_bucket_limiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sharded token bucket limiter
// Concurrent checks on internal control of the limiter, one use to a line.
// ----------------------------------------------------------------------------
`ifndef SHARDED_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define SHARDED_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/stbl_pkg.sv
// ----------------------------------------------------------------------------
// stbl_pkg
// Shared types and constants of the sharded token bucket limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stbl_pkg;

   localparam int HASH_W  = 64;
   localparam int TIME_W  = 48;
   localparam int TOKEN_W = 32;

   localparam logic [HASH_W-1:0]  HASH_BASIS   = 64'hCBF2_9CE4_8422_2325;
   localparam logic [TOKEN_W-1:0] ONE_TOKEN    = 32'h0001_0000;
   localparam logic [TOKEN_W-1:0] REFILL_RESET = 32'd655;
   localparam logic [TOKEN_W-1:0] CAP_RESET    = 32'd655360;

   // Decision queue between the hash front and the bucket back end.
   localparam int QDEPTH = 32;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFILL_PER_MS = 1'b0,
      CSR_BURST_CAP     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CALC,
      BK_APPLY
   } back_state_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [TIME_W-1:0] now;
   } hash_req_type;

   typedef struct packed {
      logic               used;
      logic [TOKEN_W-1:0] level;
      logic [TIME_W-1:0]  last;
   } bucket_type;

   typedef struct packed {
      logic clear_done;
      logic pop;
   } bk_status_type;

endpackage

`default_nettype wire

FILE: hdl/stbl_front.sv
// ----------------------------------------------------------------------------
// stbl_front
// Accepts identifier bytes, runs FNV-1a on sign-extended bytes and hands finished hashes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbl_front import stbl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        id_byte,
   input  logic              no_byte,
   input  logic              last_byte,
   input  logic [TIME_W-1:0] now_ms,
   input  bk_status_type     bk_status,
   output logic              dec_valid,
   output hash_req_type      dec_req
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic              dec_valid_ff, dec_valid_in;
   hash_req_type      dec_req_ff, dec_req_in;
   logic [QCNT_W-1:0] credit_ff, credit_in;
   logic              accept;
   logic              deciding;
   logic [HASH_W-1:0] hash_upd;

   // The FNV prime is 2^40 + 0x1B3, so the product is a handful of shifted adds.
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-8){b[7]}}, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   always_comb begin
      req_ready = bk_status.clear_done && (credit_ff < QCNT_W'(QDEPTH));
      accept    = req_valid && req_ready;
      deciding  = no_byte || last_byte;
      hash_upd  = no_byte ? hash_ff : fnv_step(hash_ff, id_byte);

      hash_in      = hash_ff;
      dec_valid_in = 1'b0;
      dec_req_in   = dec_req_ff;
      if (accept) begin
         if (deciding) begin
            hash_in        = HASH_BASIS;
            dec_valid_in   = 1'b1;
            dec_req_in.hash = hash_upd;
            dec_req_in.now  = now_ms;
         end else begin
            hash_in = hash_upd;
         end
      end

      // Each credit covers one decision anywhere between here and the back end.
      credit_in = credit_ff + QCNT_W'(accept && deciding) - QCNT_W'(bk_status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= HASH_BASIS;
         dec_valid_ff <= 1'b0;
         credit_ff    <= '0;
      end else begin
         hash_ff      <= hash_in;
         dec_valid_ff <= dec_valid_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_req_ff <= dec_req_in;
   end

   assign dec_valid = dec_valid_ff;
   assign dec_req   = dec_req_ff;

endmodule

`default_nettype wire

FILE: hdl/stbl_mod.sv
// ----------------------------------------------------------------------------
// stbl_mod
// Pipelined hash modulo shard count, one hash nibble per stage, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbl_mod import stbl_pkg::*; #(
   parameter int SHARDS = 16,
   parameter int RW     = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hash_req_type      in_req,
   output logic              out_valid,
   output logic [RW-1:0]     out_shard,
   output logic [TIME_W-1:0] out_now
);

   localparam int STAGES = HASH_W / 4;
   localparam int XW     = RW + 4;

   logic              valid_ff [STAGES];
   logic              valid_in [STAGES];
   logic [RW-1:0]     rem_ff   [STAGES];
   logic [RW-1:0]     rem_in   [STAGES];
   logic [HASH_W-1:0] hash_ff  [STAGES];
   logic [HASH_W-1:0] hash_in  [STAGES];
   logic [TIME_W-1:0] now_ff   [STAGES];
   logic [TIME_W-1:0] now_in   [STAGES];

   logic              st_valid [STAGES];
   logic [RW-1:0]     st_rem   [STAGES];
   logic [HASH_W-1:0] st_hash  [STAGES];
   logic [TIME_W-1:0] st_now   [STAGES];
   logic [XW-1:0]     st_x     [STAGES];
   logic [XW-1:0]     st_red   [STAGES];

   always_comb begin
      st_valid[0] = in_valid;
      st_rem[0]   = '0;
      st_hash[0]  = in_req.hash;
      st_now[0]   = in_req.now;
      for (int s = 1; s < STAGES; s++) begin
         st_valid[s] = valid_ff[s-1];
         st_rem[s]   = rem_ff[s-1];
         st_hash[s]  = hash_ff[s-1];
         st_now[s]   = now_ff[s-1];
      end

      // The running remainder stays below SHARDS, so the shifted value is below
      // sixteen times SHARDS and one of fifteen constant multiples is taken off.
      for (int s = 0; s < STAGES; s++) begin
         st_x[s]   = {st_rem[s], st_hash[s][HASH_W-1-4*s -: 4]};
         st_red[s] = st_x[s];
         for (int j = 1; j < 16; j++) begin
            if (st_x[s] >= XW'(j * SHARDS)) begin
               st_red[s] = st_x[s] - XW'(j * SHARDS);
            end
         end
         valid_in[s] = st_valid[s];
         rem_in[s]   = st_red[s][RW-1:0];
         hash_in[s]  = st_hash[s];
         now_in[s]   = st_now[s];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         hash_ff[s] <= hash_in[s];
         now_ff[s]  <= now_in[s];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_shard = rem_ff[STAGES-1];
   assign out_now   = now_ff[STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/stbl_queue.sv
// ----------------------------------------------------------------------------
// stbl_queue
// Small FIFO of decided requests between the hash pipeline and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbl_queue import stbl_pkg::*; #(
   parameter int W = 52
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic         head_valid,
   output logic [W-1:0] head_data,
   output logic         full
);

   localparam int AW = $clog2(QDEPTH);

   logic [W-1:0]      slot_ff [QDEPTH];
   logic [W-1:0]      slot_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      slot_in   = push_data;
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign full       = (count_ff == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

FILE: hdl/stbl_back.sv
// ----------------------------------------------------------------------------
// stbl_back
// Bucket table and refill / spend datapath: calc, then apply, which pops the next request when output is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbl_back import stbl_pkg::*; #(
   parameter int SHARDS = 16,
   parameter int RW     = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [TOKEN_W-1:0] refill_per_ms,
   input  logic [TOKEN_W-1:0] burst_cap,
   input  logic               q_valid,
   input  logic [RW-1:0]      q_shard,
   input  logic [TIME_W-1:0]  q_now,
   output bk_status_type      bk_status,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_allowed,
   output logic [3:0]         rsp_shard_index,
   output logic [TOKEN_W-1:0] rsp_tokens_left
);

   bucket_type bank_mem [SHARDS];
   bucket_type rd_data_ff;

   back_state_type     state_ff, state_in;
   logic [RW-1:0]      clr_ff, clr_in;
   logic [RW-1:0]      cur_shard_ff, cur_shard_in;
   logic [TIME_W-1:0]  cur_now_ff, cur_now_in;
   bucket_type         ent_ff, ent_in;
   logic [63:0]        prod_ff, prod_in;
   logic               big_ff, big_in;
   logic               later_ff, later_in;
   logic               fwd_ff, fwd_in;
   bucket_type         fwd_ent_ff, fwd_ent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_allowed_ff, rsp_allowed_in;
   logic [3:0]         rsp_shard_ff, rsp_shard_in;
   logic [TOKEN_W-1:0] rsp_tokens_ff, rsp_tokens_in;

   logic               mem_we;
   logic [RW-1:0]      mem_waddr;
   bucket_type         mem_wdata;
   bucket_type         cur_ent;
   logic [TIME_W-1:0]  elapsed;
   logic [TOKEN_W:0]   sum33;
   logic [TOKEN_W-1:0] refilled;
   logic [TIME_W-1:0]  new_last;
   logic               granted;
   bucket_type         new_ent;
   logic               out_free;
   logic               pop;

   always_comb begin
      // A request that follows one to the same shard takes the entry just written.
      cur_ent  = fwd_ff ? fwd_ent_ff : rd_data_ff;
      elapsed  = cur_now_ff - cur_ent.last;
      out_free = !rsp_valid_ff || rsp_ready;

      sum33 = {1'b0, ent_ff.level} + {1'b0, prod_ff[TOKEN_W-1:0]};
      if (!ent_ff.used) begin
         refilled = burst_cap;
         new_last = cur_now_ff;
      end else if (later_ff) begin
         if (big_ff || (prod_ff >= {32'b0, burst_cap}) || (sum33 >= {1'b0, burst_cap})) begin
            refilled = burst_cap;
         end else begin
            refilled = sum33[TOKEN_W-1:0];
         end
         new_last = cur_now_ff;
      end else begin
         refilled = ent_ff.level;
         new_last = ent_ff.last;
      end
      granted       = (refilled >= ONE_TOKEN);
      new_ent.used  = 1'b1;
      new_ent.level = granted ? refilled - ONE_TOKEN : refilled;
      new_ent.last  = new_last;

      state_in       = state_ff;
      clr_in         = clr_ff;
      cur_shard_in   = cur_shard_ff;
      cur_now_in     = cur_now_ff;
      ent_in         = ent_ff;
      prod_in        = prod_ff;
      big_in         = big_ff;
      later_in       = later_ff;
      fwd_in         = fwd_ff;
      fwd_ent_in     = fwd_ent_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_shard_in   = rsp_shard_ff;
      rsp_tokens_in  = rsp_tokens_ff;
      mem_we         = 1'b0;
      mem_waddr      = cur_shard_ff;
      mem_wdata      = new_ent;
      pop            = 1'b0;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == RW'(SHARDS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + RW'(1);
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               pop          = 1'b1;
               cur_shard_in = q_shard;
               cur_now_in   = q_now;
               fwd_in       = 1'b0;
               state_in     = BK_CALC;
            end
         end
         BK_CALC: begin
            ent_in   = cur_ent;
            later_in = (cur_now_ff > cur_ent.last);
            big_in   = (refill_per_ms != '0) && (elapsed[TIME_W-1:32] != '0);
            prod_in  = 64'(elapsed[31:0]) * 64'(refill_per_ms);
            state_in = BK_APPLY;
         end
         BK_APPLY: begin
            if (out_free) begin
               mem_we         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = granted;
               rsp_shard_in   = 4'(cur_shard_ff);
               rsp_tokens_in  = new_ent.level;
               if (q_valid) begin
                  pop          = 1'b1;
                  cur_shard_in = q_shard;
                  cur_now_in   = q_now;
                  fwd_in       = (q_shard == cur_shard_ff);
                  fwd_ent_in   = new_ent;
                  state_in     = BK_CALC;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_shard_ff   <= cur_shard_in;
      cur_now_ff     <= cur_now_in;
      ent_ff         <= ent_in;
      prod_ff        <= prod_in;
      big_ff         <= big_in;
      later_ff       <= later_in;
      fwd_ent_ff     <= fwd_ent_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_shard_ff   <= rsp_shard_in;
      rsp_tokens_ff  <= rsp_tokens_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bank_mem[q_shard];
   end

   assign bk_status = '{clear_done: (state_ff != BK_CLEAR), pop: pop};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_shard_index = rsp_shard_ff;
   assign rsp_tokens_left = rsp_tokens_ff;

endmodule

`default_nettype wire

FILE: hdl/sharded_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// sharded_token_bucket_limiter: sharded token bucket limiter, FNV-1a hash on sign-extended bytes.
// One identifier byte per cycle while req_ready is high; decided hashes pass modulo stages and a queue.
// The bucket read-modify-write loop in the back end pops the next request while applying one.
// After reset a sweep clears each of the SHARDS bucket entries; req_ready stays low till done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sharded_token_bucket_limiter_assert.svh"

module sharded_token_bucket_limiter import stbl_pkg::*; #(
   parameter int SHARDS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_id_byte,
   input  logic                 req_no_byte,
   input  logic                 req_last_byte,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_allowed,
   output logic [3:0]           rsp_shard_index,
   output logic [TOKEN_W-1:0]   rsp_tokens_left,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_wdata
);

   localparam int RW = (SHARDS > 1) ? $clog2(SHARDS) : 1;
   localparam int QW = RW + TIME_W;

   logic [TOKEN_W-1:0] refill_ff, refill_in;
   logic [TOKEN_W-1:0] cap_ff, cap_in;

   bk_status_type     bk_status;
   logic              dec_valid;
   hash_req_type      dec_req;
   logic              mod_valid;
   logic [RW-1:0]     mod_shard;
   logic [TIME_W-1:0] mod_now;
   logic              q_head_valid;
   logic [QW-1:0]     q_head_data;
   logic              q_full;

   always_comb begin
      refill_in = refill_ff;
      cap_in    = cap_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_REFILL_PER_MS: refill_in = csr_wdata;
            CSR_BURST_CAP:     cap_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= REFILL_RESET;
         cap_ff    <= CAP_RESET;
      end else begin
         refill_ff <= refill_in;
         cap_ff    <= cap_in;
      end
   end

   stbl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .id_byte   (req_id_byte),
      .no_byte   (req_no_byte),
      .last_byte (req_last_byte),
      .now_ms    (req_now_ms),
      .bk_status (bk_status),
      .dec_valid (dec_valid),
      .dec_req   (dec_req)
   );

   stbl_mod #(
      .SHARDS (SHARDS),
      .RW     (RW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_req    (dec_req),
      .out_valid (mod_valid),
      .out_shard (mod_shard),
      .out_now   (mod_now)
   );

   stbl_queue #(
      .W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (mod_valid),
      .push_data  ({mod_shard, mod_now}),
      .pop        (bk_status.pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .full       (q_full)
   );

   stbl_back #(
      .SHARDS (SHARDS),
      .RW     (RW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .refill_per_ms   (refill_ff),
      .burst_cap       (cap_ff),
      .q_valid         (q_head_valid),
      .q_shard         (q_head_data[QW-1:TIME_W]),
      .q_now           (q_head_data[TIME_W-1:0]),
      .bk_status       (bk_status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_allowed     (rsp_allowed),
      .rsp_shard_index (rsp_shard_index),
      .rsp_tokens_left (rsp_tokens_left)
   );

   // Credits in the front end keep the queue from ever being pushed while full.
   `STBL_ASSERT_SAME(a_queue_no_overflow, clock, reset, mod_valid, !q_full, "decision pushed into full queue")
   `STBL_ASSERT_SAME(a_pop_has_item, clock, reset, bk_status.pop, q_head_valid, "back end popped an empty queue")
   `STBL_ASSERT_SAME(a_rsp_after_clear, clock, reset, rsp_valid, bk_status.clear_done, "response during table clear")
   `STBL_ASSERT_NEXT(a_pop_spacing, clock, reset, bk_status.pop, !bk_status.pop, "back end popped two cycles in a row")

endmodule

`default_nettype wire

FILE: dv/tb_sharded_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// tb_sharded_token_bucket_limiter
// Self-checking bench for the sharded token bucket limiter. A directed table
// covers the boundary cases. Then random tenant identifiers are streamed under
// several refill and burst settings. A behavioral bucket model predicts each
// decision, and random gaps and stalls are applied on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sharded_token_bucket_limiter;
   import stbl_pkg::*;

   localparam int                NUM_BUCKETS   = 16;
   localparam logic [HASH_W-1:0] FNV_PRIME     = 64'd1099511628211;
   localparam int                SETTLE_CYCLES = 64;
   localparam int                STALL_LIMIT   = 4000;
   localparam int                REPORT_MAX    = 10;
   localparam int                PHASE_ITEMS   = 107;

   typedef struct packed {
      logic [7:0]        id_byte;
      logic              no_byte;
      logic              last_byte;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic               allowed;
      logic [3:0]         shard;
      logic [TOKEN_W-1:0] tokens;
   } decision_type;

   typedef struct {
      bit                 cfg_write;
      csr_index_type      cfg_reg;
      logic [TOKEN_W-1:0] cfg_value;
      req_item_type       item;
      bit                 typed;
      decision_type       want;
   } step_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_id_byte;
   logic                 req_no_byte;
   logic                 req_last_byte;
   logic [TIME_W-1:0]    req_now_ms;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_allowed;
   logic [3:0]           rsp_shard_index;
   logic [TOKEN_W-1:0]   rsp_tokens_left;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TOKEN_W-1:0]   csr_wdata;

   sharded_token_bucket_limiter #(.SHARDS(NUM_BUCKETS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_id_byte     (req_id_byte),
      .req_no_byte     (req_no_byte),
      .req_last_byte   (req_last_byte),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_allowed     (rsp_allowed),
      .rsp_shard_index (rsp_shard_index),
      .rsp_tokens_left (rsp_tokens_left),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Bucket model state and its copy of the registers.
   logic [HASH_W-1:0]  tenant_hash;
   logic [TOKEN_W-1:0] bucket_level [NUM_BUCKETS];
   logic [TIME_W-1:0]  bucket_last  [NUM_BUCKETS];
   bit                 bucket_used  [NUM_BUCKETS];
   logic [TOKEN_W-1:0] cfg_refill;
   logic [TOKEN_W-1:0] cfg_cap;

   decision_type       awaited_decisions[$];
   step_row_type       directed_steps[$];

   logic [7:0]         pool_bytes [8][8];
   int                 pool_len   [8];
   logic [TIME_W-1:0]  wall_ms;

   int items_sent;
   int requests_sent;
   int settings_used;
   int responses_checked;
   int allowed_seen;
   int denied_seen;
   int mismatch_count;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [TOKEN_W-1:0] topped_up(input logic [TOKEN_W-1:0] level,
                                                    input logic [TIME_W-1:0]  elapsed);
      logic [63:0] add;
      logic [63:0] sum;
      if (cfg_refill != '0 && elapsed > 48'h0000_FFFF_FFFF)
         return cfg_cap;
      add = 64'(elapsed) * 64'(cfg_refill);
      sum = 64'(level) + add;
      if (add >= 64'(cfg_cap) || sum >= 64'(cfg_cap))
         return cfg_cap;
      return sum[TOKEN_W-1:0];
   endfunction

   // Hashes the byte unless no_byte is set and, on a deciding transaction, settles the chosen bucket.
   function automatic bit hash_and_decide(input req_item_type it, output decision_type d);
      logic [3:0]        b;
      logic [HASH_W-1:0] ext;
      d = '0;
      if (!it.no_byte) begin
         ext = {{56{it.id_byte[7]}}, it.id_byte};
         tenant_hash = (tenant_hash ^ ext) * FNV_PRIME;
      end
      if (!it.no_byte && !it.last_byte)
         return 1'b0;
      b = 4'(tenant_hash % 64'(NUM_BUCKETS));
      tenant_hash = HASH_BASIS;
      if (!bucket_used[b]) begin
         bucket_used[b]  = 1'b1;
         bucket_level[b] = cfg_cap;
         bucket_last[b]  = it.now_ms;
      end else if (it.now_ms > bucket_last[b]) begin
         bucket_level[b] = topped_up(bucket_level[b], it.now_ms - bucket_last[b]);
         bucket_last[b]  = it.now_ms;
      end
      d.allowed = (bucket_level[b] >= ONE_TOKEN);
      if (d.allowed)
         bucket_level[b] = bucket_level[b] - ONE_TOKEN;
      d.shard  = b;
      d.tokens = bucket_level[b];
      return 1'b1;
   endfunction

   function automatic logic [TIME_W-1:0] random_ms();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic int pick_gap(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly small forward steps, with repeats, backward steps and big jumps.
   function automatic void advance_wall_ms();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         wall_ms = wall_ms + $urandom_range(1, 30);
      else if (r < 67)
         wall_ms = wall_ms;
      else if (r < 76)
         wall_ms = wall_ms - $urandom_range(1, 50);
      else if (r < 86)
         wall_ms = wall_ms + $urandom_range(1000, 100000);
      else if (r < 92)
         wall_ms = wall_ms + TIME_W'({$urandom_range(1, 255), 32'h0});
      else if (r < 95)
         wall_ms = 48'hFFFF_FFFF_FF00 + $urandom_range(0, 200);
      else
         wall_ms = random_ms();
   endfunction

   function automatic step_row_type item_row(input logic [7:0]        id,
                                             input bit                nob,
                                             input bit                last,
                                             input logic [TIME_W-1:0] now_ms);
      step_row_type s;
      s.cfg_write      = 1'b0;
      s.cfg_reg        = CSR_REFILL_PER_MS;
      s.cfg_value      = '0;
      s.item.id_byte   = id;
      s.item.no_byte   = nob;
      s.item.last_byte = last;
      s.item.now_ms    = now_ms;
      s.typed          = 1'b0;
      s.want           = '0;
      return s;
   endfunction

   function automatic step_row_type typed_row(input logic [TIME_W-1:0]  now_ms,
                                              input bit                 ok,
                                              input logic [3:0]         shard,
                                              input logic [TOKEN_W-1:0] left);
      step_row_type s;
      s              = item_row(8'h00, 1'b1, 1'b1, now_ms);
      s.typed        = 1'b1;
      s.want.allowed = ok;
      s.want.shard   = shard;
      s.want.tokens  = left;
      return s;
   endfunction

   function automatic step_row_type reg_row(input csr_index_type idx,
                                            input logic [TOKEN_W-1:0] v);
      step_row_type s;
      s           = item_row(8'h00, 1'b0, 1'b0, '0);
      s.cfg_write = 1'b1;
      s.cfg_reg   = idx;
      s.cfg_value = v;
      return s;
   endfunction

   // Entered and left at a falling edge.
   task automatic send_item(input req_item_type it, input int gap, input bit typed,
                            input decision_type want);
      decision_type d;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_id_byte   <= it.id_byte;
      req_no_byte   <= it.no_byte;
      req_last_byte <= it.last_byte;
      req_now_ms    <= it.now_ms;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      items_sent++;
      if (hash_and_decide(it, d)) begin
         requests_sent++;
         awaited_decisions.push_back(typed ? want : d);
      end
      @(negedge clock);
   endtask

   // The sender holds off until every outstanding decision has come back.
   task automatic drain_decisions();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (awaited_decisions.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [TOKEN_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx == CSR_REFILL_PER_MS)
         cfg_refill = v;
      else
         cfg_cap = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [TOKEN_W-1:0] refill, input logic [TOKEN_W-1:0] cap);
      drain_decisions();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(CSR_REFILL_PER_MS, refill);
      write_reg(CSR_BURST_CAP, cap);
      settings_used++;
   endtask

   task automatic send_request(input bit steady);
      logic [7:0]   bytes [8];
      int           len;
      int           slot;
      int           r;
      req_item_type it;
      r = $urandom_range(0, 99);
      if (r < 7) begin
         len = 0;
      end else if (r < 72) begin
         slot  = $urandom_range(0, 7);
         len   = pool_len[slot];
         bytes = pool_bytes[slot];
      end else begin
         len = $urandom_range(1, 8);
         foreach (bytes[k])
            bytes[k] = 8'($urandom);
      end
      advance_wall_ms();
      if (len == 0) begin
         it.id_byte   = 8'($urandom);
         it.no_byte   = 1'b1;
         it.last_byte = 1'($urandom_range(0, 1));
         it.now_ms    = wall_ms;
         send_item(it, pick_gap(steady), 1'b0, '0);
      end else begin
         for (int k = 0; k < len; k++) begin
            it.id_byte   = bytes[k];
            it.no_byte   = 1'b0;
            it.last_byte = (k == len - 1);
            it.now_ms    = (k == len - 1) ? wall_ms : random_ms();
            send_item(it, pick_gap(steady), 1'b0, '0);
         end
      end
   endtask

   function automatic void report_mismatch(input string what, input decision_type want,
                                           input decision_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t: %s: allowed exp %0d got %0d, shard exp %0d got %0d, %s %08h got %08h",
                  $realtime, what, want.allowed, got.allowed, want.shard, got.shard,
                  "tokens exp", want.tokens, got.tokens);
   endfunction

   always @(posedge clock) begin : decision_check
      decision_type want;
      decision_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.allowed = rsp_allowed;
         got.shard   = rsp_shard_index;
         got.tokens  = rsp_tokens_left;
         responses_checked++;
         if (got.allowed === 1'b1)
            allowed_seen++;
         else
            denied_seen++;
         if (awaited_decisions.size() == 0) begin
            report_mismatch("response with no request pending", '0, got);
         end else begin
            want = awaited_decisions.pop_front();
            if (got.allowed !== want.allowed || got.shard !== want.shard ||
                got.tokens !== want.tokens)
               report_mismatch("decision mismatch", want, got);
         end
      end
   end

   // Ends the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : rsp_pacing
      int run;
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 200) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         hold = pick_gap(1'b0);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [TOKEN_W-1:0] refill_set [7];
      logic [TOKEN_W-1:0] cap_set    [7];
      int                 phase_end;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_id_byte   = '0;
      req_no_byte   = 1'b0;
      req_last_byte = 1'b0;
      req_now_ms    = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      tenant_hash   = HASH_BASIS;
      cfg_refill    = REFILL_RESET;
      cfg_cap       = CAP_RESET;
      foreach (bucket_used[i]) begin
         bucket_used[i]  = 1'b0;
         bucket_level[i] = '0;
         bucket_last[i]  = '0;
      end
      foreach (pool_len[i]) begin
         pool_len[i] = $urandom_range(1, 6);
         foreach (pool_bytes[i][k])
            pool_bytes[i][k] = 8'($urandom);
      end

      // Empty identifiers land in the shard given by the offset basis alone.
      directed_steps.push_back(typed_row(48'd1000, 1'b1, 4'd5, 32'd589824));
      directed_steps.push_back(typed_row(48'd1000, 1'b1, 4'd5, 32'd524288));
      directed_steps.push_back(typed_row(48'd999,  1'b1, 4'd5, 32'd458752));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'd1100));
      directed_steps.push_back(item_row(8'h5A, 1'b1, 1'b0, 48'd1100));
      directed_steps.push_back(item_row(8'h00, 1'b0, 1'b0, 48'hAAAA_5555_AAAA));
      directed_steps.push_back(item_row(8'hFF, 1'b0, 1'b0, 48'h5555_AAAA_5555));
      directed_steps.push_back(item_row(8'h80, 1'b0, 1'b0, 48'd0));
      directed_steps.push_back(item_row(8'h7F, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF));
      directed_steps.push_back(item_row(8'h41, 1'b0, 1'b1, 48'd2000));
      directed_steps.push_back(item_row(8'hFF, 1'b0, 1'b1, 48'd0));
      directed_steps.push_back(reg_row(CSR_REFILL_PER_MS, 32'hFFFF_FFFF));
      directed_steps.push_back(reg_row(CSR_BURST_CAP, 32'hFFFF_FFFF));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'd1200));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'h0002_0000_04B0));
      // Lowering the cap pulls an overfull bucket down on its next refill.
      directed_steps.push_back(reg_row(CSR_REFILL_PER_MS, 32'd0));
      directed_steps.push_back(reg_row(CSR_BURST_CAP, 32'h0001_0000));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'h0003_0000_0000));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'h0003_0000_0001));
      // A cap under one token always denies once refilled.
      directed_steps.push_back(reg_row(CSR_BURST_CAP, 32'd30000));
      directed_steps.push_back(reg_row(CSR_REFILL_PER_MS, 32'd1));
      directed_steps.push_back(item_row(8'h00, 1'b1, 1'b1, 48'h0003_0001_0000));
      directed_steps.push_back(item_row(8'h10, 1'b0, 1'b1, 48'h0003_0002_0000));
      directed_steps.push_back(item_row(8'h33, 1'b0, 1'b1, 48'h0003_0002_0000));

      refill_set = '{REFILL_RESET, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'($urandom),
                     32'd3000};
      cap_set    = '{CAP_RESET, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd196608,
                     $urandom_range(32'hFFFF_FFFF, 32'h0001_0000), 32'd131072};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].cfg_write) begin
            drain_decisions();
            repeat (SETTLE_CYCLES) @(negedge clock);
            write_reg(directed_steps[i].cfg_reg, directed_steps[i].cfg_value);
         end else begin
            send_item(directed_steps[i].item, pick_gap(1'b0), directed_steps[i].typed,
                      directed_steps[i].want);
         end
      end

      wall_ms = 48'h0000_0010_0000 + $urandom_range(0, 100000);
      for (int p = 0; p < 7; p++) begin
         apply_setting(refill_set[p], cap_set[p]);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            send_request(p % 3 == 2);
            if ($urandom_range(0, 99) < 3)
               drain_decisions();
         end
      end

      drain_decisions();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d byte transactions forming %0d requests under %0d register settings.",
               items_sent, requests_sent, settings_used);
      $display("Checked %0d decisions: %0d allowed, %0d denied; %0d mismatches.",
               responses_checked, allowed_seen, denied_seen, mismatch_count);
      if (mismatch_count == 0 && awaited_decisions.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/stbl_pkg.sv
hdl/stbl_front.sv
hdl/stbl_mod.sv
hdl/stbl_queue.sv
hdl/stbl_back.sv
hdl/sharded_token_bucket_limiter.sv
dv/tb_sharded_token_bucket_limiter.sv
